// File: hdl/ilda_pkg.sv
// ----------------------------------------------------------------------------
// ILDA stream parser package
// Shared item types, operation codes and constant tables.
// ----------------------------------------------------------------------------
package ilda_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int CMD_DEPTH     = 4;
  localparam int OUT_DEPTH     = 2;

  localparam logic [2:0] FMT_3D_IDX  = 3'd0;
  localparam logic [2:0] FMT_2D_IDX  = 3'd1;
  localparam logic [2:0] FMT_PALETTE = 3'd2;
  localparam logic [2:0] FMT_3D_TRUE = 3'd4;
  localparam logic [2:0] FMT_2D_TRUE = 3'd5;

  localparam logic [7:0] Magic [4] = '{8'h49, 8'h4C, 8'h44, 8'h41};

  localparam logic [23:0] DfltPal [64] = '{
    24'hFF0000, 24'hFF1000, 24'hFF2000, 24'hFF3000,
    24'hFF4000, 24'hFF5000, 24'hFF6000, 24'hFF7000,
    24'hFF8000, 24'hFF9000, 24'hFFA000, 24'hFFB000,
    24'hFFC000, 24'hFFD000, 24'hFFE000, 24'hFFF000,
    24'hFFFF00, 24'hE0FF00, 24'hC0FF00, 24'hA0FF00,
    24'h80FF00, 24'h60FF00, 24'h40FF00, 24'h20FF00,
    24'h00FF00, 24'h00FF24, 24'h00FF49, 24'h00FF6D,
    24'h00FF92, 24'h00FFB6, 24'h00FFDB, 24'h00FFFF,
    24'h00E3FF, 24'h00C6FF, 24'h00AAFF, 24'h008EFF,
    24'h0071FF, 24'h0055FF, 24'h0038FF, 24'h001CFF,
    24'h0000FF, 24'h2000FF, 24'h4000FF, 24'h6000FF,
    24'h8000FF, 24'hA000FF, 24'hC000FF, 24'hE000FF,
    24'hFF00FF, 24'hFF20FF, 24'hFF40FF, 24'hFF60FF,
    24'hFF80FF, 24'hFFA0FF, 24'hFFC0FF, 24'hFFE0FF,
    24'hFFFFFF, 24'hFFE0E0, 24'hFFC0C0, 24'hFFA0A0,
    24'hFF8080, 24'hFF6060, 24'hFF4040, 24'hFF2020
  };

  typedef enum logic [2:0] {
    KIND_POINT      = 3'd0,
    KIND_POINT_END  = 3'd1,
    KIND_FILE_END   = 3'd2,
    KIND_BAD_MAGIC  = 3'd3,
    KIND_BAD_FORMAT = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ERR_MAGIC,
    OP_ERR_FMT,
    OP_END,
    OP_PAL,
    OP_POINT
  } op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] frame_index;
    logic        last_of_frame;
    logic [15:0] box_x_min;
    logic [15:0] box_x_max;
    logic [15:0] box_y_min;
    logic [15:0] box_y_max;
  } out_t;

  typedef struct packed {
    op_e         op;
    logic        restart;
    logic        pal_start;
    logic        eof;
    logic        last;
    logic        true_color;
    logic        blank;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [15:0] frame;
  } cmd_t;

  function automatic logic [3:0] rec_width(input logic [2:0] fmt);
    logic [3:0] w;
    case (fmt)
      FMT_3D_IDX:  w = 4'd8;
      FMT_2D_IDX:  w = 4'd6;
      FMT_PALETTE: w = 4'd3;
      FMT_3D_TRUE: w = 4'd10;
      default:     w = 4'd8;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/ilda_fifo.sv
// ----------------------------------------------------------------------------
// ILDA small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module ilda_fifo #(
  parameter type item_t = logic,
  parameter int  Depth  = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  item_t         mem_q [Depth];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ilda_front.sv
// ----------------------------------------------------------------------------
// ILDA byte front end
// Walks section headers and records and issues one command per event.
// ----------------------------------------------------------------------------
module ilda_front import ilda_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  in_t  item_i,
  output logic cmd_push_o,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_REC,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d, ph;
  logic [4:0]  pos_q, pos_d, p;
  logic [2:0]  fmt_q, fmt_d;
  logic [15:0] recs_q, recs_d;
  logic [15:0] frame_q, frame_d;
  logic [15:0] total_q, total_d;
  logic [7:0]  bytes_q [10];
  logic [7:0]  rec [10];
  logic [7:0]  b, status;
  logic        emit, is_end, more, wide;
  logic [3:0]  w;
  cmd_t        cmd;

  assign b = item_i.data_byte;

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      rec[i] = (p[3:0] == 4'(i)) ? b : bytes_q[i];
    end
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    fmt_d   = fmt_q;
    recs_d  = recs_q;
    frame_d = frame_q;
    total_d = total_q;
    cmd     = '0;
    emit    = 1'b0;
    ph      = phase_q;
    p       = pos_q;
    w       = rec_width(fmt_q);
    is_end  = 1'b0;
    more    = 1'b0;
    wide    = (fmt_q == FMT_3D_IDX) || (fmt_q == FMT_3D_TRUE);
    status  = wide ? rec[6] : rec[4];
    if (item_i.file_start) begin
      ph          = PH_HEAD;
      p           = '0;
      cmd.restart = 1'b1;
      emit        = 1'b1;
    end
    cmd.op    = OP_NOP;
    cmd.frame = frame_q;
    case (ph)
      PH_HEAD: begin
        if (p < 5'd4 && b != Magic[p[1:0]]) begin
          cmd.op  = OP_ERR_MAGIC;
          emit    = 1'b1;
          phase_d = PH_DONE;
        end else if (p == 5'd7 && !(b == 8'(FMT_3D_IDX) || b == 8'(FMT_2D_IDX) ||
                     b == 8'(FMT_PALETTE) || b == 8'(FMT_3D_TRUE) ||
                     b == 8'(FMT_2D_TRUE))) begin
          cmd.op  = OP_ERR_FMT;
          emit    = 1'b1;
          phase_d = PH_DONE;
        end else begin
          phase_d = PH_HEAD;
          if (p == 5'd7)  fmt_d   = b[2:0];
          if (p == 5'd24) recs_d  = {b, 8'h00};
          if (p == 5'd25) recs_d  = {recs_q[15:8], b};
          if (p == 5'd26) frame_d = {b, 8'h00};
          if (p == 5'd27) frame_d = {frame_q[15:8], b};
          if (p == 5'd28) total_d = {b, 8'h00};
          if (p == 5'd29) total_d = {total_q[15:8], b};
          if (p != 5'd31) begin
            pos_d = p + 1'b1;
          end else begin
            pos_d = '0;
            if (fmt_q == FMT_PALETTE) begin
              cmd.pal_start = 1'b1;
              emit          = 1'b1;
            end
            if (recs_q == '0) begin
              cmd.op  = OP_END;
              emit    = 1'b1;
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_REC;
            end
          end
        end
      end
      PH_REC: begin
        if ({1'b0, p} + 6'd1 < {2'b00, w}) begin
          pos_d = p + 1'b1;
        end else begin
          pos_d  = '0;
          recs_d = recs_q - 1'b1;
          is_end = (recs_d == '0);
          more   = ({1'b0, frame_q} + 17'd1) < {1'b0, total_q};
          if (is_end) begin
            phase_d = more ? PH_HEAD : PH_DONE;
          end
          cmd.eof  = is_end && !more;
          cmd.last = is_end;
          emit     = 1'b1;
          if (fmt_q == FMT_PALETTE) begin
            cmd.op = OP_PAL;
            cmd.c0 = rec[0];
            cmd.c1 = rec[1];
            cmd.c2 = rec[2];
          end else begin
            cmd.op         = OP_POINT;
            cmd.px         = {rec[0] ^ 8'h80, rec[1]};
            cmd.py         = 16'h7FFF - {rec[2], rec[3]};
            cmd.blank      = status[6];
            cmd.true_color = (fmt_q == FMT_3D_TRUE) || (fmt_q == FMT_2D_TRUE);
            if (cmd.true_color) begin
              cmd.c0 = wide ? rec[9] : rec[7];
              cmd.c1 = wide ? rec[8] : rec[6];
              cmd.c2 = wide ? rec[7] : rec[5];
            end else begin
              cmd.c0 = wide ? rec[7] : rec[5];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_push_o = accept_i && emit;
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i) begin
    if (accept_i && ph == PH_REC && p < 5'd10) begin
      bytes_q[p[3:0]] <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      fmt_q   <= '0;
      recs_q  <= '0;
      frame_q <= '0;
      total_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      fmt_q   <= fmt_d;
      recs_q  <= recs_d;
      frame_q <= frame_d;
      total_q <= total_d;
    end
  end

endmodule

// File: hdl/ilda_back.sv
// ----------------------------------------------------------------------------
// ILDA back end
// Executes commands: palette memory, color lookup and bounding box.
// ----------------------------------------------------------------------------
module ilda_back import ilda_pkg::*; #(
  parameter int PaletteDepth = PALETTE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output out_t res_o
);

  localparam int AW = $clog2(PaletteDepth);
  localparam int FW = $clog2(PaletteDepth + 1);

  logic [23:0]             pal_mem [PaletteDepth];
  logic [PaletteDepth-1:0] pal_vld_q;
  logic [FW-1:0]           fill_q;
  logic [23:0]             rd_q;
  logic                    rd_vld_q;
  logic                    s1_v_q;
  cmd_t                    s1_q;
  logic                    s1_adv, do_pop, wr_en, has_res;
  logic [15:0]             box_q [4];
  logic [15:0]             box_c [4];
  logic [15:0]             box_n [4];
  logic [23:0]             col;
  out_t                    res;

  assign s1_adv    = s1_v_q && !res_full_i;
  assign do_pop    = !cmd_empty_i && (!s1_v_q || !res_full_i);
  assign cmd_pop_o = do_pop;
  assign wr_en     = do_pop && !cmd_i.restart && !cmd_i.pal_start && cmd_i.op == OP_PAL &&
                     fill_q < FW'(PaletteDepth);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pal_mem[fill_q[AW-1:0]] <= {cmd_i.c0, cmd_i.c1, cmd_i.c2};
    end
    if (do_pop) begin
      rd_q     <= pal_mem[cmd_i.c0[AW-1:0]];
      rd_vld_q <= pal_vld_q[cmd_i.c0[AW-1:0]];
      s1_q     <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
      fill_q    <= FW'(64);
      s1_v_q    <= 1'b0;
    end else begin
      if (do_pop) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (do_pop && cmd_i.restart) begin
        pal_vld_q <= '0;
        fill_q    <= FW'(64);
      end else if (do_pop && cmd_i.pal_start) begin
        fill_q <= '0;
      end else if (wr_en) begin
        pal_vld_q[fill_q[AW-1:0]] <= 1'b1;
        fill_q                    <= fill_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (32'(s1_q.c0) >= PaletteDepth) begin
      col = '0;
    end else if (rd_vld_q) begin
      col = rd_q;
    end else if (s1_q.c0 < 8'd64) begin
      col = DfltPal[s1_q.c0[5:0]];
    end else begin
      col = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      box_c[i] = s1_q.restart ? ((i % 2 == 0) ? 16'hFFFF : 16'h0000) : box_q[i];
    end
    box_n    = box_c;
    res      = '0;
    has_res  = 1'b0;
    case (s1_q.op)
      OP_ERR_MAGIC: begin
        res.kind = KIND_BAD_MAGIC;
        has_res  = 1'b1;
      end
      OP_ERR_FMT: begin
        res.kind = KIND_BAD_FORMAT;
        has_res  = 1'b1;
      end
      OP_END: begin
        res.kind = KIND_FILE_END;
        has_res  = 1'b1;
      end
      OP_PAL: begin
        res.kind          = KIND_FILE_END;
        res.last_of_frame = 1'b1;
        has_res           = s1_q.eof;
      end
      OP_POINT: begin
        if (s1_q.px < box_c[0]) box_n[0] = s1_q.px;
        if (s1_q.px > box_c[1]) box_n[1] = s1_q.px;
        if (s1_q.py < box_c[2]) box_n[2] = s1_q.py;
        if (s1_q.py > box_c[3]) box_n[3] = s1_q.py;
        res.kind          = s1_q.eof ? KIND_POINT_END : KIND_POINT;
        res.pos_x         = s1_q.px;
        res.pos_y         = s1_q.py;
        res.last_of_frame = s1_q.last;
        if (!s1_q.blank) begin
          if (s1_q.true_color) begin
            {res.red, res.green, res.blue} = {s1_q.c0, s1_q.c1, s1_q.c2};
          end else begin
            {res.red, res.green, res.blue} = col;
          end
        end
        has_res = 1'b1;
      end
      default: begin
      end
    endcase
    if (s1_q.op == OP_END || s1_q.op == OP_PAL || s1_q.op == OP_POINT) begin
      res.frame_index = s1_q.frame;
      res.box_x_min   = box_n[0];
      res.box_x_max   = box_n[1];
      res.box_y_min   = box_n[2];
      res.box_y_max   = box_n[3];
    end
  end

  assign res_push_o = s1_adv && has_res;
  assign res_o      = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q[0] <= 16'hFFFF;
      box_q[1] <= 16'h0000;
      box_q[2] <= 16'hFFFF;
      box_q[3] <= 16'h0000;
    end else if (s1_adv) begin
      box_q <= box_n;
    end
  end

endmodule

// File: hdl/ilda_stream_parser.sv
// ----------------------------------------------------------------------------
// ILDA stream parser
// Parses an ILDA laser-show byte stream into points and file events.
// ----------------------------------------------------------------------------
// Usage: file bytes enter through push/full with in_item_i; an item is taken
// at a clock edge with push high and full low. Set file_start on the first
// byte of each file. Results leave through empty/pop with out_item_o; the
// oldest result is shown while empty is low and is taken when pop is high.
// The block takes one byte per clock while full is low. A result passes
// from the front parser into the command queue, then through the back-end
// stage register, whose palette memory has a registered read port, and
// then into the result queue. A four-entry command queue sits
// between the front and back ends and a two-entry result queue sits at
// the output, so the input keeps flowing while a result waits. When the
// receiver stalls, the queues fill and full rises. After reset the parser
// is idle and ignores bytes until a file start; the palette holds the
// default 64 colours and the bounding box is empty.
// ----------------------------------------------------------------------------
module ilda_stream_parser import ilda_pkg::*; #(
  parameter int PaletteDepth = PALETTE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  in_item_i,
  output logic empty,
  input  logic pop,
  output out_t out_item_o
);

  logic accept, cmd_push, cmd_full, cmd_empty, cmd_pop, res_push, res_full;
  cmd_t cmd_in, cmd_out;
  out_t res;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  ilda_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  ilda_fifo #(.item_t(cmd_t), .Depth(CMD_DEPTH)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  ilda_back #(.PaletteDepth(PaletteDepth)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  ilda_fifo #(.item_t(out_t), .Depth(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

`ifndef SYNTHESIS
  a_cmd_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_full |-> !cmd_empty) else $error("command queue full and empty");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_item_o.kind == KIND_BAD_MAGIC || out_item_o.kind == KIND_BAD_FORMAT))
    |-> (out_item_o.pos_x == '0 && out_item_o.red == '0 && out_item_o.box_x_min == '0))
    else $error("error result carries data");

  a_point_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_item_o.kind == KIND_POINT || out_item_o.kind == KIND_POINT_END))
    |-> (out_item_o.box_x_min <= out_item_o.pos_x && out_item_o.pos_x <= out_item_o.box_x_max
         && out_item_o.box_y_min <= out_item_o.pos_y
         && out_item_o.pos_y <= out_item_o.box_y_max))
    else $error("point outside bounding box");
`endif

endmodule
